### rtl/ipp_pkg.sv
// Shared types and constants for the interval priority painter.
package ipp_pkg;

    localparam int MAX_SPANS_DEF = 64;
    localparam int COORD_W       = 16;
    localparam int COLOR_W       = 16;

    localparam logic [COORD_W-1:0] LINE_LENGTH_RST = COORD_W'(1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PAINT = 1'b1;

    // Query token that walks the cell chain, one cell per cycle while the chain advances.
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] pos;
        logic [COLOR_W-1:0] color;
    } ipp_token_t;

endpackage

### rtl/ipp_cell.sv
// One painter cell: holds a single interval and repaints a passing query token.
module ipp_cell
    import ipp_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [COORD_W-1:0] wr_start,
    input  logic [COORD_W-1:0] wr_end,
    input  logic [COLOR_W-1:0] wr_color,
    input  logic [CNT_W-1:0]   span_count,
    input  logic               advance,
    input  ipp_token_t         tok_in,
    output ipp_token_t         tok_out
);

    logic [COORD_W-1:0] start_reg;
    logic [COORD_W-1:0] end_reg;
    logic [COLOR_W-1:0] color_reg;
    ipp_token_t         tok_reg;
    ipp_token_t         tok_next;
    logic               live;
    logic               hit;

    // The cell takes part only once its interval has been loaded in this job.
    assign live = (span_count > CNT_W'(CELL_IDX));
    assign hit  = live && (start_reg <= tok_in.pos) && (tok_in.pos < end_reg);

    always_comb begin
        tok_next       = tok_in;
        tok_next.color = hit ? color_reg : tok_in.color;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
            color_reg <= wr_color;
        end
    end

    // Only the valid bit is reset; the payload simply follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg.valid <= tok_next.valid;
        end
        if (advance) begin
            tok_reg.pos   <= tok_next.pos;
            tok_reg.color <= tok_next.color;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/interval_priority_painter_unit.sv
// Top level of the interval priority painter: control, cell chain and output register.
//
// The painter builds one line of pixels from colored intervals, the interval loaded
// last winning wherever several overlap. An input word with tuser = 0 loads one
// interval (start inclusive, end exclusive, color) into the next free cell; loads
// beyond MAX_SPANS are dropped. An input word with tuser = 1 asks for the color at
// the current position, which comes out as one output word; uncovered positions
// read as color 0. The word for the final position of the line (line_length set on
// the configuration port, 0 meaning 65536) carries tlast, after which the stored
// intervals and the position are cleared for the next line. A paint request walks
// a query token through the chain of MAX_SPANS cells, one cell per cycle while the
// output side does not stall, from the oldest interval to the newest. The token
// passes the launch register and then the register of each cell, and no new word
// is accepted until its result has moved into the output register. The output
// register lets a new load or request be taken while the previous result still
// waits to be read.
module interval_priority_painter_unit
    import ipp_pkg::*;
#(
    parameter int MAX_SPANS = MAX_SPANS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration: line_length.
    input  logic                      cfg_wr_en,
    input  logic [COORD_W-1:0]        cfg_wr_data,
    // Input stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata fields, low to high: span_start[15:0], span_end[31:16], paint_color[47:32].
    input  logic [2*COORD_W+COLOR_W-1:0] s_tdata,
    // tuser fields, low to high: opcode[0].
    input  logic                      s_tuser,
    // Output stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata fields, low to high: pixel_color[15:0].
    output logic [COLOR_W-1:0]        m_tdata,
    // tlast carries line_done.
    output logic                      m_tlast
);

    localparam int CNT_W = $clog2(MAX_SPANS + 1);

    // Input word fields.
    logic [COORD_W-1:0] in_start;
    logic [COORD_W-1:0] in_end;
    logic [COLOR_W-1:0] in_color;

    assign in_start = s_tdata[COORD_W-1:0];
    assign in_end   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_color = s_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];

    // Control state.
    logic [COORD_W-1:0] line_length_reg;
    logic [CNT_W-1:0]   span_count_reg;
    logic [COORD_W-1:0] cursor_reg;
    logic               busy_reg;
    logic               done_pend_reg;
    logic               m_valid_reg;
    logic               m_last_reg;
    logic [COLOR_W-1:0] m_color_reg;
    ipp_token_t         launch_reg;

    logic               in_fire;
    logic               load_fire;
    logic               paint_fire;
    logic               at_last;
    logic [COORD_W-1:0] last_pos;
    logic               result_load;
    logic               advance;

    ipp_token_t         chain [MAX_SPANS+1];
    logic [MAX_SPANS-1:0] cell_wr;

    // Only one word is in the chain at a time; loads wait for a running request.
    assign s_tready   = !busy_reg;
    assign in_fire    = s_tvalid && s_tready;
    assign load_fire  = in_fire && (s_tuser == OP_LOAD);
    assign paint_fire = in_fire && (s_tuser == OP_PAINT);

    // The final position wraps modulo 2^16, so a length of 0 means 65536 positions.
    assign last_pos = line_length_reg - COORD_W'(1);
    assign at_last  = (cursor_reg == last_pos);

    // The token leaving the last cell goes to the output register when it is free.
    assign result_load = chain[MAX_SPANS].valid && (!m_valid_reg || m_tready);
    assign advance     = !(chain[MAX_SPANS].valid && !result_load);

    assign chain[0] = launch_reg;

    generate
        for (genvar i = 0; i < MAX_SPANS; i++) begin : g_cell
            assign cell_wr[i] = load_fire && (span_count_reg == CNT_W'(i));

            ipp_cell #(
                .CELL_IDX (i),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .wr_en      (cell_wr[i]),
                .wr_start   (in_start),
                .wr_end     (in_end),
                .wr_color   (in_color),
                .span_count (span_count_reg),
                .advance    (advance),
                .tok_in     (chain[i]),
                .tok_out    (chain[i+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LINE_LENGTH_RST;
        end else if (cfg_wr_en) begin
            line_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_count_reg   <= '0;
            cursor_reg       <= '0;
            busy_reg         <= 1'b0;
            done_pend_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
            launch_reg.valid <= 1'b0;
        end else begin
            // A new interval counts only while there is a free cell for it.
            if (load_fire && (span_count_reg < CNT_W'(MAX_SPANS))) begin
                span_count_reg <= span_count_reg + CNT_W'(1);
            end

            if (paint_fire) begin
                busy_reg         <= 1'b1;
                done_pend_reg    <= at_last;
                launch_reg.valid <= 1'b1;
                launch_reg.pos   <= cursor_reg;
                launch_reg.color <= '0;
                cursor_reg       <= at_last ? '0 : cursor_reg + COORD_W'(1);
            end else if (advance) begin
                launch_reg.valid <= 1'b0;
            end

            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // The intervals stay in use until the final pixel has left the chain.
            if (result_load) begin
                m_valid_reg <= 1'b1;
                busy_reg    <= 1'b0;
                if (done_pend_reg) begin
                    span_count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            m_color_reg <= chain[MAX_SPANS].color;
            m_last_reg  <= done_pend_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_color_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // The interval count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        span_count_reg <= CNT_W'(MAX_SPANS))
        else $error("span count above capacity");

    // While a request walks the chain, the set of live cells must not change.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !result_load |=> $stable(span_count_reg))
        else $error("span count changed during a paint request");

    // Finishing the final pixel of a line clears the intervals and the position.
    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load && done_pend_reg |=> (span_count_reg == '0) && (cursor_reg == '0))
        else $error("line end did not clear state");

    // A token can only reach the end of the chain while a request is running.
    a_token_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_SPANS].valid |-> busy_reg)
        else $error("token in chain without a running request");

    // An accepted paint request occupies the block on the next cycle.
    a_launch_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        paint_fire |=> busy_reg && !s_tready)
        else $error("paint request did not occupy the block");
`endif

endmodule

### tb/sv/interval_priority_painter_unit_tb.sv
// Self-checking testbench for the interval priority painter: a line predictor and scoreboard.
`timescale 1ns / 1ps

// One expected or observed output word: the painted color and the end-of-line flag.
typedef struct packed {
    logic [ipp_pkg::COLOR_W-1:0] color;
    logic                        done;
} pixel_word_t;

// Keeps a private copy of the painter state and predicts every output word.
class line_paint_scoreboard;
    logic [ipp_pkg::COORD_W-1:0] lo_edge [ipp_pkg::MAX_SPANS_DEF];
    logic [ipp_pkg::COORD_W-1:0] hi_edge [ipp_pkg::MAX_SPANS_DEF];
    logic [ipp_pkg::COLOR_W-1:0] ink     [ipp_pkg::MAX_SPANS_DEF];
    int                          span_total;
    logic [ipp_pkg::COORD_W-1:0] cursor;
    logic [ipp_pkg::COORD_W-1:0] line_len;
    pixel_word_t                 pixels_due[$];
    int                          errors;

    function new();
        span_total = 0;
        cursor     = '0;
        line_len   = ipp_pkg::LINE_LENGTH_RST;
        errors     = 0;
    endfunction

    // Called for every accepted input word.
    function void take_word(logic op, logic [ipp_pkg::COORD_W-1:0] lo,
                            logic [ipp_pkg::COORD_W-1:0] hi,
                            logic [ipp_pkg::COLOR_W-1:0] col);
        pixel_word_t                 px;
        logic [ipp_pkg::COORD_W-1:0] last_pos;
        int                          k;
        logic                        hit;
        if (op == ipp_pkg::OP_LOAD) begin
            if (span_total < ipp_pkg::MAX_SPANS_DEF) begin
                lo_edge[span_total] = lo;
                hi_edge[span_total] = hi;
                ink[span_total]     = col;
                span_total++;
            end
        end else begin
            last_pos = line_len - 16'd1;
            px.done  = (cursor == last_pos);
            px.color = '0;
            hit      = 1'b0;
            for (k = span_total - 1; k >= 0 && !hit; k--) begin
                if (lo_edge[k] <= cursor && cursor < hi_edge[k]) begin
                    px.color = ink[k];
                    hit      = 1'b1;
                end
            end
            pixels_due.push_back(px);
            if (px.done) begin
                span_total = 0;
                cursor     = '0;
            end else begin
                cursor = cursor + 16'd1;
            end
        end
    endfunction

    // Called for every accepted output word.
    function void check_pixel(logic [ipp_pkg::COLOR_W-1:0] color, logic done);
        pixel_word_t want;
        if (pixels_due.size() == 0) begin
            errors++;
            if (errors <= 40)
                $display("%0t: unexpected output word, actual color %h last %b",
                         $time, color, done);
        end else begin
            want = pixels_due.pop_front();
            if (color !== want.color) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: color mismatch, expected %h actual %h",
                             $time, want.color, color);
            end
            if (done !== want.done) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: tlast mismatch, expected %b actual %b",
                             $time, want.done, done);
            end
        end
    endfunction
endclass

module interval_priority_painter_unit_tb
    import ipp_pkg::*;
();

    // After the last expected word the bench waits on until the cell chain has emptied
    // before the block counts as idle.
    localparam int DRAIN_CYCLES   = MAX_SPANS_DEF + 8;
    localparam int WORD_TARGET    = 1800;
    localparam int CALM_FROM      = 1500;
    localparam int HOLD_AT        = 600;
    localparam int HOLD_CYCLES    = 600;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [COORD_W-1:0]           cfg_wr_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [2*COORD_W+COLOR_W-1:0] s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [COLOR_W-1:0]           m_tdata;
    logic                         m_tlast;

    line_paint_scoreboard sb;
    int   words_sent;
    logic calm;
    logic long_hold_req;
    logic held_once;

    interval_priority_painter_unit #(
        .MAX_SPANS(MAX_SPANS_DEF)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A hard stop in case the block hangs or drops words.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("interval_priority_painter_unit_tb: FAIL");
        $finish;
    end

    // Every accepted output word is checked against the oldest prediction. The
    // prediction for a word was made when its paint request was accepted, which is
    // always well before the word comes out, so the order of processes at one edge does not matter.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata, m_tlast);
    end

    // Output side. It stalls in short random bursts, once holds off for a long
    // stretch so that the output register holds a word, the token waits at the end of
    // the cell chain and the input stalls, and never stalls in the last part of the run.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Offers one word and waits until it is taken. Afterwards the input may go
    // quiet for a short random burst; otherwise tvalid simply stays high for the
    // next word.
    task automatic send_word(logic op, logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi,
                             logic [COLOR_W-1:0] col);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {col, hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Loads that hit a full store are dropped by the block and do not count.
        if (op == OP_PAINT || sb.span_total < MAX_SPANS_DEF)
            words_sent++;
        sb.take_word(op, lo, hi, col);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // A paint request ignores its data fields, so they carry random values.
    task automatic paint_pixel();
        send_word(OP_PAINT, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Waits until every predicted word has come out and the chain has emptied.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The length register is only written while the block is idle.
    task automatic write_length(logic [COORD_W-1:0] len);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.line_len = len;
    endtask

    // One interval with random content. Most intervals sit on or near the line so
    // that they overlap and win over each other; some are reversed or empty, and a
    // few use the whole 16-bit range.
    task automatic load_random_span();
        int                 len;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        len = int'(sb.line_len);
        if ($urandom_range(0, 9) == 0) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
        end else begin
            lo = 16'($urandom_range(0, len + 1));
            if ($urandom_range(0, 5) == 0)
                hi = 16'($urandom_range(0, len + 1));
            else
                hi = lo + 16'($urandom_range(1, len + 1));
        end
        send_word(OP_LOAD, lo, hi, 16'($urandom));
    endtask

    // Paints one whole line: loads mixed with paint requests, now and then a line with
    // nearly as many loads as the interval store holds or more, and now and then a
    // length change partway through the line.
    task automatic paint_random_line(int min_len);
        int   pick;
        int   loads_left;
        int   paints_left;
        int   paints_done;
        int   new_len;
        logic fill;
        fill = ($urandom_range(0, 11) == 0);
        if (min_len > 0) begin
            write_length(16'($urandom_range(min_len, min_len + 6)));
        end else if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                write_length(16'($urandom_range(1, 10)));
            else if (pick < 19)
                write_length(16'($urandom_range(11, 40)));
            else
                write_length(16'd1);
        end
        paints_left = int'(sb.line_len) - int'(sb.cursor);
        paints_done = 0;
        loads_left  = fill ? $urandom_range(60, 70) : $urandom_range(0, 8);
        while (paints_left > 0) begin
            if (loads_left > 0 && (fill || $urandom_range(0, 3) != 0)) begin
                load_random_span();
                loads_left--;
            end else begin
                if (paints_done > 0 && paints_left > 1 && $urandom_range(0, 19) == 0) begin
                    // The cursor stays at or below the new final position.
                    new_len = int'(sb.cursor) + $urandom_range(1, 6);
                    write_length(16'(new_len));
                    paints_left = new_len - int'(sb.cursor);
                end
                paint_pixel();
                paints_left--;
                paints_done++;
            end
        end
    endtask

    initial begin
        sb            = new();
        words_sent    = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        held_once     = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_LOAD;
        s_tdata     <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset length of one, the first paint request is already the
        // end of a line and nothing covers it.
        paint_pixel();

        // An interval spanning the whole range, a reversed one, a later interval
        // that wins in the middle, an empty one, then an interval loaded mid-line
        // that takes over from the next position on.
        write_length(16'd8);
        send_word(OP_LOAD, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_word(OP_LOAD, 16'hFFFF, 16'h0000, 16'h0000);
        send_word(OP_LOAD, 16'd2, 16'd5, 16'h1234);
        send_word(OP_LOAD, 16'd3, 16'd3, 16'hAAAA);
        paint_pixel();
        paint_pixel();
        paint_pixel();
        send_word(OP_LOAD, 16'd0, 16'd8, 16'h5555);
        repeat (5) paint_pixel();

        // The largest length, then a shorter one whose final position is exactly
        // where the cursor stands.
        write_length(16'hFFFF);
        paint_pixel();
        paint_pixel();
        write_length(16'd3);
        paint_pixel();

        // Length zero means a 65536-position line; it is cut short the same way.
        write_length(16'd0);
        paint_pixel();
        write_length(16'd2);
        paint_pixel();

        // Random lines until enough words have gone in. One line runs with the
        // long output hold-off, and the last stretch runs without any idling.
        while (words_sent < WORD_TARGET) begin
            calm = (words_sent >= CALM_FROM);
            if (!held_once && words_sent >= HOLD_AT) begin
                held_once     = 1'b1;
                long_hold_req = 1'b1;
                paint_random_line(10);
            end else begin
                paint_random_line(0);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pixels_due.size() == 0)
            $display("interval_priority_painter_unit_tb: PASS");
        else
            $display("interval_priority_painter_unit_tb: FAIL");
        $finish;
    end

endmodule
